@@ rtl/sct_pkg.sv @@
`timescale 1ns / 1ps
// sct_pkg: shared types and constants for the CIF/STAR tokenizer.
// No dependencies; used by sct_token_if and all tokenizer modules.
package sct_pkg;

  // Width of the reported start offset and length fields.
  localparam int TOK_BITS = 32;

  typedef enum logic [1:0] {
    KIND_BARE   = 2'd0,
    KIND_QUOTED = 2'd1,
    KIND_TEXT   = 2'd2
  } tok_kind_t;

  typedef struct packed {
    logic [TOK_BITS-1:0] start;
    logic [TOK_BITS-1:0] length;
    tok_kind_t           kind;
    logic                unterm;
  } tok_t;

endpackage

@@ rtl/sct_byte_if.sv @@
`timescale 1ns / 1ps
// sct_byte_if: valid/ready channel carrying one text byte per word.
// No dependencies.
interface sct_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

@@ rtl/sct_token_if.sv @@
`timescale 1ns / 1ps
// sct_token_if: valid/ready channel carrying one token descriptor per word.
// Depends on sct_pkg for the field widths.
interface sct_token_if import sct_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [TOK_BITS-1:0] token_start;
  logic [TOK_BITS-1:0] token_length;
  logic [1:0]          token_kind;
  logic                unterminated;

  modport source (output valid, output token_start, output token_length,
                  output token_kind, output unterminated, input ready);
  modport sink   (input valid, input token_start, input token_length,
                  input token_kind, input unterminated, output ready);
endinterface

@@ rtl/sct_scan.sv @@
`timescale 1ns / 1ps
// sct_scan: scanner state and per-byte token boundary logic.
// Depends on sct_pkg (tok_t, token kinds).
module sct_scan import sct_pkg::*; #(
  parameter int OFFSET_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  output logic       tok_valid,
  output tok_t       tok
);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SEMI   = 8'h3B;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_BARE    = 3'd2,
    MODE_QUOTED  = 3'd3,
    MODE_TEXT    = 3'd4
  } mode_t;

  mode_t                  mode, mode_next;
  logic                   quote_single, quote_single_next;
  logic                   quote_pending, quote_pending_next;
  logic                   last_lf, last_lf_next;
  logic [OFFSET_BITS-1:0] byte_position, byte_position_next;
  logic [OFFSET_BITS-1:0] open_start, open_start_next;

  logic                   is_lf, is_sp;
  logic [7:0]             quote_ch;
  logic [OFFSET_BITS-1:0] pos_m1, pos_p1, end_pos, len_full;
  tok_kind_t              kind;
  logic                   cut;

  assign is_lf    = (data_byte == CH_CR) || (data_byte == CH_LF);
  assign is_sp    = is_lf || (data_byte == CH_SPACE) || (data_byte == CH_TAB);
  assign quote_ch = quote_single ? CH_SQUOTE : CH_DQUOTE;
  assign pos_m1   = byte_position - OFFSET_BITS'(1);
  assign pos_p1   = byte_position + OFFSET_BITS'(1);

  always_comb begin
    mode_next          = mode;
    quote_single_next  = quote_single;
    quote_pending_next = quote_pending;
    last_lf_next       = last_lf;
    open_start_next    = open_start;
    byte_position_next = pos_p1;
    tok_valid          = 1'b0;
    end_pos            = byte_position;
    kind               = KIND_BARE;
    cut                = 1'b0;

    if (data_byte == CH_NUL) begin
      // end of contents: flush the open token, then back to reset state
      unique case (mode)
        MODE_BARE: begin
          tok_valid = 1'b1;
        end
        MODE_QUOTED: begin
          tok_valid = 1'b1;
          kind      = KIND_QUOTED;
          if (quote_pending) begin
            end_pos = pos_m1;
          end else begin
            cut = 1'b1;
          end
        end
        MODE_TEXT: begin
          tok_valid = 1'b1;
          kind      = KIND_TEXT;
          cut       = 1'b1;
        end
        default: begin
        end
      endcase
      mode_next          = MODE_IDLE;
      quote_single_next  = 1'b0;
      quote_pending_next = 1'b0;
      last_lf_next       = 1'b0;
      open_start_next    = '0;
      byte_position_next = '0;
    end else begin
      unique case (mode)
        MODE_COMMENT: begin
          if (is_lf) begin
            mode_next    = MODE_IDLE;
            last_lf_next = 1'b1;
          end
        end
        MODE_BARE: begin
          if (is_sp) begin
            tok_valid    = 1'b1;
            mode_next    = MODE_IDLE;
            last_lf_next = is_lf;
          end
        end
        MODE_QUOTED: begin
          if (quote_pending && is_sp) begin
            tok_valid          = 1'b1;
            kind               = KIND_QUOTED;
            end_pos            = pos_m1;
            mode_next          = MODE_IDLE;
            quote_pending_next = 1'b0;
            last_lf_next       = is_lf;
          end else begin
            // a run of quotes keeps the close pending
            quote_pending_next = (data_byte == quote_ch);
          end
        end
        MODE_TEXT: begin
          if (last_lf && data_byte == CH_SEMI) begin
            tok_valid    = 1'b1;
            kind         = KIND_TEXT;
            end_pos      = pos_m1;
            mode_next    = MODE_IDLE;
            last_lf_next = 1'b0;
          end else begin
            last_lf_next = is_lf;
          end
        end
        default: begin
          // idle between tokens
          if (is_sp) begin
            last_lf_next = is_lf;
          end else if (data_byte == CH_HASH) begin
            mode_next    = MODE_COMMENT;
            last_lf_next = 1'b0;
          end else if (data_byte == CH_DQUOTE || data_byte == CH_SQUOTE) begin
            mode_next          = MODE_QUOTED;
            quote_single_next  = (data_byte == CH_SQUOTE);
            quote_pending_next = 1'b0;
            open_start_next    = pos_p1;
            last_lf_next       = 1'b0;
          end else if (data_byte == CH_SEMI && last_lf) begin
            mode_next       = MODE_TEXT;
            open_start_next = pos_p1;
            last_lf_next    = 1'b0;
          end else begin
            mode_next       = MODE_BARE;
            open_start_next = byte_position;
            last_lf_next    = 1'b0;
          end
        end
      endcase
    end
  end

  assign len_full = end_pos - open_start;

  // offsets reported in their low TOK_BITS bits
  generate
    if (OFFSET_BITS >= TOK_BITS) begin : g_trunc
      assign tok.start  = open_start[TOK_BITS-1:0];
      assign tok.length = len_full[TOK_BITS-1:0];
    end else begin : g_ext
      assign tok.start  = {{(TOK_BITS-OFFSET_BITS){1'b0}}, open_start};
      assign tok.length = {{(TOK_BITS-OFFSET_BITS){1'b0}}, len_full};
    end
  endgenerate
  assign tok.kind   = kind;
  assign tok.unterm = cut;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      quote_single  <= 1'b0;
      quote_pending <= 1'b0;
      last_lf       <= 1'b0;
      byte_position <= '0;
      open_start    <= '0;
    end else if (accept) begin
      mode          <= mode_next;
      quote_single  <= quote_single_next;
      quote_pending <= quote_pending_next;
      last_lf       <= last_lf_next;
      byte_position <= byte_position_next;
      open_start    <= open_start_next;
    end
  end

`ifndef ASSERT_OFF
  a_nul_resets: assert property (@(posedge clk) disable iff (rst)
    accept && data_byte == CH_NUL |=> mode == MODE_IDLE && byte_position == '0)
    else $error("scanner not reset after end of contents");

  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    accept && data_byte != CH_NUL |=>
      byte_position == $past(byte_position) + OFFSET_BITS'(1))
    else $error("byte position did not advance");

  a_bare_clean: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok.kind == KIND_BARE |-> !tok.unterm)
    else $error("bare token flagged unterminated");

  a_pending_only_quoted: assert property (@(posedge clk) disable iff (rst)
    quote_pending |-> mode == MODE_QUOTED)
    else $error("quote pending outside a string");
`endif

endmodule

@@ rtl/sct_out_stage.sv @@
`timescale 1ns / 1ps
// sct_out_stage: result register plus skid entry between scanner and sink.
// Depends on sct_pkg (tok_t).
module sct_out_stage import sct_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  tok_t push_tok,
  output logic can_accept,
  output logic out_valid,
  input  logic out_ready,
  output tok_t out_tok
);

  logic main_valid, skid_valid;
  tok_t main_tok, skid_tok;
  logic pop;

  assign pop        = main_valid && out_ready;
  assign can_accept = !skid_valid;
  assign out_valid  = main_valid;
  assign out_tok    = main_tok;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        main_tok   <= skid_tok;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_tok   <= push_tok;
        main_valid <= 1'b1;
      end else begin
        skid_tok   <= push_tok;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

endmodule

@@ rtl/star_cif_tokenizer_unit.sv @@
`timescale 1ns / 1ps
// star_cif_tokenizer_unit: top level of the CIF/STAR token boundary scanner.
// Depends on sct_pkg, sct_byte_if, sct_token_if, sct_scan, sct_out_stage.
//
// Usage:
//   byte_in carries one text byte per word; a zero byte ends the contents.
//   token_out carries one word per finished token: start offset (after any
//   opening quote or ';'), length (closing delimiters excluded), kind
//   (bare, quoted string, text field) and an unterminated flag.
//   Throughput: one byte per cycle while the skid entry is free. The scanner
//   updates its state in the same cycle a byte is accepted; the token it
//   closes (on whitespace, closing ';' or the zero byte) is registered in the
//   result register, or in the skid entry while that register holds a token.
//   Backpressure: the result register has a one-word skid entry behind it,
//   so a byte is still taken while a token waits; byte_in.ready drops only
//   when both entries are full, and rises again once the sink takes one.
//   Reset (rst, synchronous): scanner goes idle at offset zero, both result
//   entries are emptied. A zero byte has the same effect on the scanner after
//   it flushes any open token.
//   Offsets wrap modulo 2^OFFSET_BITS and are reported in their low 32 bits.
module star_cif_tokenizer_unit import sct_pkg::*; #(
  parameter int OFFSET_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  sct_byte_if.sink     byte_in,
  sct_token_if.source  token_out
);

  logic accept;
  logic tok_valid;
  tok_t tok;
  logic can_accept;
  tok_t out_tok;

  // a byte is taken whenever the skid entry is free
  assign byte_in.ready = can_accept;
  assign accept        = byte_in.valid && can_accept;

  sct_scan #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (byte_in.data_byte),
    .tok_valid (tok_valid),
    .tok       (tok)
  );

  sct_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (accept && tok_valid),
    .push_tok   (tok),
    .can_accept (can_accept),
    .out_valid  (token_out.valid),
    .out_ready  (token_out.ready),
    .out_tok    (out_tok)
  );

  assign token_out.token_start  = out_tok.start;
  assign token_out.token_length = out_tok.length;
  assign token_out.token_kind   = out_tok.kind;
  assign token_out.unterminated = out_tok.unterm;

endmodule

@@ tb/sv/tb_star_cif_tokenizer_unit.sv @@
`timescale 1ns / 1ps
// tb_star_cif_tokenizer_unit: self-checking bench for the CIF/STAR token scanner.
// Depends on sct_pkg, sct_byte_if, sct_token_if and star_cif_tokenizer_unit.
module tb_star_cif_tokenizer_unit;
  import sct_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_PRINTS  = 40;

  // Characters the scanner cares about.
  localparam logic [7:0] CH_END    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_DASH   = 8'h2D;

  typedef enum logic [2:0] {
    SCAN_IDLE    = 3'd0,
    SCAN_COMMENT = 3'd1,
    SCAN_BARE    = 3'd2,
    SCAN_QUOTED  = 3'd3,
    SCAN_TEXT    = 3'd4
  } scan_mode_t;

  logic clk;
  logic rst;

  sct_byte_if  byte_ch ();
  sct_token_if tok_ch ();

  star_cif_tokenizer_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_ch),
    .token_out (tok_ch)
  );

  // Scanner state as the bench tracks it, advanced once per accepted byte word.
  scan_mode_t  scan_mode;
  logic        quote_single;
  logic        quote_pending;
  logic        after_lf;
  logic [31:0] cur_offset;
  logic [31:0] tok_begin;

  // Tokens the block still owes, oldest first.
  tok_t pending_tokens[$];

  int mismatches    = 0;
  int bytes_sent    = 0;
  int cycles        = 0;
  int burst_left    = 0;
  int cut_countdown = -1;

  logic [7:0] dir_seq[$];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------
  function automatic logic is_lf(logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return is_lf(c) || (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function void clear_scanner();
    scan_mode     = SCAN_IDLE;
    quote_single  = 1'b0;
    quote_pending = 1'b0;
    after_lf      = 1'b0;
    cur_offset    = '0;
    tok_begin     = '0;
  endfunction

  function void owe_token(logic [31:0] end_off, tok_kind_t kind, logic cut);
    tok_t t;
    t.start  = tok_begin;
    t.length = end_off - tok_begin;
    t.kind   = kind;
    t.unterm = cut;
    pending_tokens.insert(pending_tokens.size(), t);
  endfunction

  function void scan_byte(logic [7:0] c);
    logic [31:0] pos;
    logic [7:0]  q;
    pos = cur_offset;
    q   = quote_single ? CH_SQUOTE : CH_DQUOTE;
    // End of contents: flush the open token, then back to reset state.
    if (c == CH_END) begin
      case (scan_mode)
        SCAN_BARE: owe_token(pos, KIND_BARE, 1'b0);
        SCAN_QUOTED: begin
          // a quote still waiting for whitespace closes the string
          if (quote_pending) owe_token(pos - 32'd1, KIND_QUOTED, 1'b0);
          else owe_token(pos, KIND_QUOTED, 1'b1);
        end
        SCAN_TEXT: owe_token(pos, KIND_TEXT, 1'b1);
        default: ;
      endcase
      clear_scanner();
      return;
    end
    case (scan_mode)
      SCAN_COMMENT: begin
        if (is_lf(c)) begin
          scan_mode = SCAN_IDLE;
          after_lf  = 1'b1;
        end
      end
      SCAN_BARE: begin
        if (is_blank(c)) begin
          owe_token(pos, KIND_BARE, 1'b0);
          scan_mode = SCAN_IDLE;
          after_lf  = is_lf(c);
        end
      end
      SCAN_QUOTED: begin
        if (quote_pending && is_blank(c)) begin
          owe_token(pos - 32'd1, KIND_QUOTED, 1'b0);
          scan_mode     = SCAN_IDLE;
          quote_pending = 1'b0;
          after_lf      = is_lf(c);
        end else begin
          quote_pending = (c == q);
        end
      end
      SCAN_TEXT: begin
        // field closes on line end + ';'; both are left out of the length
        if (after_lf && c == CH_SEMI) begin
          owe_token(pos - 32'd1, KIND_TEXT, 1'b0);
          scan_mode = SCAN_IDLE;
          after_lf  = 1'b0;
        end else begin
          after_lf = is_lf(c);
        end
      end
      default: begin
        if (is_blank(c)) begin
          after_lf = is_lf(c);
        end else if (c == CH_HASH) begin
          scan_mode = SCAN_COMMENT;
          after_lf  = 1'b0;
        end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
          scan_mode     = SCAN_QUOTED;
          quote_single  = (c == CH_SQUOTE);
          quote_pending = 1'b0;
          tok_begin     = pos + 32'd1;
          after_lf      = 1'b0;
        end else if (c == CH_SEMI && after_lf) begin
          scan_mode = SCAN_TEXT;
          tok_begin = pos + 32'd1;
          after_lf  = 1'b0;
        end else begin
          scan_mode = SCAN_BARE;
          tok_begin = pos;
          after_lf  = 1'b0;
        end
      end
    endcase
    cur_offset = pos + 32'd1;
  endfunction

  // ---------------------------------------------------------------------------
  // Byte sender: bursts of random length, random gaps between them
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? 0 : int'($urandom_range(1, 6));
      if (gap > 0) begin
        byte_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // now and then a long run with no gaps at all
      burst_left = ($urandom_range(0, 9) == 0) ? 150 : int'($urandom_range(1, 24));
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= c;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    scan_byte(c);
    burst_left--;
    bytes_sent++;
  endtask

  // Sends a byte of a generated record; a pending cut drops the rest of the
  // record and ends the contents early, leaving the token open.
  task automatic put_byte(input logic [7:0] c);
    if (cut_countdown == 0) return;
    send_byte(c);
    if (cut_countdown > 0) begin
      cut_countdown--;
      if (cut_countdown == 0) send_byte(CH_END);
    end
  endtask

  task automatic play_seq();
    foreach (dir_seq[i]) send_byte(dir_seq[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Token sink: stall pattern in phases (open, coin flip, every third, long hold)
  // ---------------------------------------------------------------------------
  initial begin
    int ready_phase;
    int phase_left;
    ready_phase  = 0;
    phase_left   = 0;
    tok_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (phase_left == 0) begin
        ready_phase = int'($urandom_range(0, 3));
        phase_left  = int'($urandom_range(5, 60));
      end
      phase_left--;
      case (ready_phase)
        0:       tok_ch.ready <= 1'b1;
        1:       tok_ch.ready <= ($urandom_range(0, 1) == 1);
        2:       tok_ch.ready <= (phase_left % 3 == 0);
        default: tok_ch.ready <= (phase_left < 2);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: every accepted token word against the oldest owed token
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("cycle %0d: token %s mismatch, got %0h want %0h", cycles, what, got, want);
  endtask

  always @(posedge clk) begin
    tok_t want;
    if (!rst && tok_ch.valid && tok_ch.ready) begin
      if (pending_tokens.size() == 0) begin
        report_mismatch("unexpected", tok_ch.token_start, 32'd0);
      end else begin
        want = pending_tokens.pop_front();
        if (tok_ch.token_start !== want.start)
          report_mismatch("start", tok_ch.token_start, want.start);
        if (tok_ch.token_length !== want.length)
          report_mismatch("length", tok_ch.token_length, want.length);
        if (tok_ch.token_kind !== want.kind)
          report_mismatch("kind", {30'd0, tok_ch.token_kind}, {30'd0, want.kind});
        if (tok_ch.unterminated !== want.unterm)
          report_mismatch("unterminated", {31'd0, tok_ch.unterminated}, {31'd0, want.unterm});
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Random content generators
  // ---------------------------------------------------------------------------
  // any byte but zero and line ends, mostly printable
  function automatic logic [7:0] body_byte();
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 3) != 0) c = 8'($urandom_range(32, 126));
      else c = 8'($urandom_range(1, 255));
    end while (is_lf(c));
    return c;
  endfunction

  function automatic logic [7:0] word_byte();
    logic [7:0] c;
    do c = body_byte(); while (is_blank(c));
    return c;
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] line_end();
    return ($urandom_range(0, 1) == 1) ? CH_CR : CH_LF;
  endfunction

  task automatic send_bare();
    logic [7:0] c;
    do c = word_byte();
    while (c == CH_HASH || c == CH_DQUOTE || c == CH_SQUOTE || c == CH_SEMI);
    put_byte(c);
    repeat ($urandom_range(0, 9)) put_byte(word_byte());
  endtask

  task automatic send_quoted();
    logic [7:0] q;
    int         pick;
    q = ($urandom_range(0, 1) == 1) ? CH_SQUOTE : CH_DQUOTE;
    put_byte(q);
    repeat ($urandom_range(0, 8)) begin
      pick = int'($urandom_range(0, 7));
      if (pick == 0) put_byte(q);
      else if (pick == 1) put_byte(CH_SPACE);
      else put_byte(body_byte());
    end
    put_byte(q);
    if ($urandom_range(0, 4) == 0) put_byte(q);
  endtask

  task automatic send_text_field();
    logic [7:0] c;
    int         lines;
    put_byte(line_end());
    put_byte(CH_SEMI);
    lines = int'($urandom_range(0, 3));
    for (int l = 0; l < lines; l++) begin
      if (l > 0) put_byte(line_end());
      for (int i = 0; i < int'($urandom_range(0, 8)); i++) begin
        c = body_byte();
        // a ';' opening a line would close the field early
        if (i == 0 && c == CH_SEMI) c = CH_DASH;
        put_byte(c);
      end
    end
    put_byte(line_end());
    put_byte(CH_SEMI);
  endtask

  task automatic send_comment();
    put_byte(CH_HASH);
    repeat ($urandom_range(0, 10)) put_byte(body_byte());
    put_byte(line_end());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // ';' at offset 0 is bare; text field "t"; ';' right after the closed field
  // is bare again; zero byte flushes it.
  task automatic test_leading_semicolon();
    dir_seq = '{CH_SEMI, CH_SPACE, CH_LF, CH_SEMI, 8'h74, CH_LF, CH_SEMI, CH_SEMI,
                CH_END};
    play_seq();
  endtask

  // Run of quotes keeps the close pending; pending quote at the zero byte.
  task automatic test_repeated_quote();
    dir_seq = '{CH_SQUOTE, 8'h61, CH_SQUOTE, CH_SQUOTE, CH_END};
    play_seq();
  endtask

  // Byte extremes inside a string and a bare token, then zero inside a comment.
  task automatic test_byte_extremes();
    dir_seq = '{CH_DQUOTE, 8'hFF, CH_DQUOTE, CH_SPACE, 8'h80, 8'h01, CH_TAB,
                CH_HASH, 8'h7F, CH_END};
    play_seq();
  endtask

  // Text field cut off by the end keeps its trailing CR.
  task automatic test_open_field_end();
    dir_seq = '{CH_LF, CH_SEMI, 8'h78, CH_CR, CH_END};
    play_seq();
  endtask

  task automatic test_cut_string();
    dir_seq = '{CH_DQUOTE, 8'h71, CH_END};
    play_seq();
  endtask

  // Zero bytes while idle produce nothing.
  task automatic test_idle_end();
    dir_seq = '{CH_END, CH_SPACE, CH_END};
    play_seq();
  endtask

  // Well-formed records with random content; some get cut short by a zero byte.
  task automatic test_random_records(input int count);
    int stop;
    int pick;
    stop = bytes_sent + count;
    while (bytes_sent < stop) begin
      cut_countdown = ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 8)) : -1;
      pick = int'($urandom_range(0, 19));
      if (pick < 7) send_bare();
      else if (pick < 12) send_quoted();
      else if (pick < 15) send_text_field();
      else if (pick < 17) send_comment();
      else if (pick == 17) put_byte(CH_END);
      cut_countdown = -1;
      repeat ($urandom_range(1, 2)) put_byte(blank_byte());
    end
  endtask

  // Sender holds off until the block has delivered every owed token.
  task automatic test_drain_pause();
    byte_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_tokens.size() != 0);
  endtask

  // Raw bytes, weighted toward the characters that change state.
  task automatic test_random_noise(input int count);
    logic [7:0] c;
    int         pick;
    repeat (count) begin
      pick = int'($urandom_range(0, 9));
      if (pick < 5) begin
        c = 8'($urandom_range(0, 255));
      end else if (pick < 8) begin
        case ($urandom_range(0, 8))
          0: c = CH_SPACE;
          1: c = CH_TAB;
          2: c = CH_CR;
          3: c = CH_LF;
          4: c = CH_HASH;
          5: c = CH_SEMI;
          6: c = CH_DQUOTE;
          7: c = CH_SQUOTE;
          default: c = CH_END;
        endcase
      end else begin
        c = 8'h61;
      end
      send_byte(c);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst               = 1'b1;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = 8'h00;
    clear_scanner();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_leading_semicolon();
    test_repeated_quote();
    test_byte_extremes();
    test_open_field_end();
    test_cut_string();
    test_idle_end();
    test_random_records(450);
    test_drain_pause();
    test_random_records(400);
    test_random_noise(200);

    // all words sent: wait for the owed tokens, then a short tail for strays
    byte_ch.valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
